FILE: rtl/core/pdc_pkg.sv
`timescale 1ns / 1ps

package pdc_pkg;

  localparam int unsigned FREQ_BITS_DEF = 32;
  localparam int unsigned CFG_INDEX_W = 4;
  localparam logic [31:0] MAX_RESET = 32'd262143;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_REF_FREQ = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IF_EXP = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IF_N_MAX = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IF_R_MAX = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RF1_N_MAX = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RF1_R_MAX = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_RF2_N_MAX = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_RF2_R_MAX = 4'd7;

  // channel kinds
  localparam logic [1:0] KIND_IF = 2'd0;
  localparam logic [1:0] KIND_RF1 = 2'd1;

  // result status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_LOAD    = 3'd1,
    OP_HALVE   = 3'd2,
    OP_REDUCE  = 3'd3,
    OP_INIT_N  = 3'd4,
    OP_INIT_R  = 3'd5,
    OP_DIV     = 3'd6,
    OP_RESULT  = 3'd7
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic zero;
    logic both_even;
    logic gcd_done;
    logic div_last;
  } dp_stat_t;

  typedef struct packed {
    logic [31:0] osc_hz;
    logic [1:0]  if_exp;
    logic [31:0] if_n_max;
    logic [31:0] if_r_max;
    logic [31:0] rf1_n_max;
    logic [31:0] rf1_r_max;
    logic [31:0] rf2_n_max;
    logic [31:0] rf2_r_max;
  } cfg_t;

endpackage

FILE: rtl/core/pll_divider_calc.sv
`timescale 1ns / 1ps
// channel  handshake            payload
// in       in_valid/in_ready    kind, target_frequency
// out      out_valid/out_ready  status, n_divider, r_divider
// cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one item at a time: load, zero check, common factors of two, binary gcd
// reduction, two restoring divisions at one quotient bit per cycle, result; a
// zero operand goes from the zero check straight to the result
// the next transfer is taken while a result still waits; a stalled result holds
// the controller in its last state; synchronous reset clears control, sets the
// reference and exponent to zero and the limits to MAX_RESET

module pll_divider_calc import pdc_pkg::*; #(
  parameter int unsigned FREQ_BITS = FREQ_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             kind,
  input  logic [31:0]            target_frequency,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             status,
  output logic [31:0]            n_divider,
  output logic [31:0]            r_divider,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.osc_hz    <= '0;
      cfg.if_exp    <= '0;
      cfg.if_n_max  <= MAX_RESET;
      cfg.if_r_max  <= MAX_RESET;
      cfg.rf1_n_max <= MAX_RESET;
      cfg.rf1_r_max <= MAX_RESET;
      cfg.rf2_n_max <= MAX_RESET;
      cfg.rf2_r_max <= MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REF_FREQ:  cfg.osc_hz    <= cfg_data;
        REG_IF_EXP:    cfg.if_exp    <= cfg_data[1:0];
        REG_IF_N_MAX:  cfg.if_n_max  <= cfg_data;
        REG_IF_R_MAX:  cfg.if_r_max  <= cfg_data;
        REG_RF1_N_MAX: cfg.rf1_n_max <= cfg_data;
        REG_RF1_R_MAX: cfg.rf1_r_max <= cfg_data;
        REG_RF2_N_MAX: cfg.rf2_n_max <= cfg_data;
        REG_RF2_R_MAX: cfg.rf2_r_max <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pdc_dp #(
    .FREQ_BITS (FREQ_BITS)
  ) u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .cfg              (cfg),
    .kind             (kind),
    .target_frequency (target_frequency),
    .stat             (stat),
    .status           (status),
    .n_divider        (n_divider),
    .r_divider        (r_divider)
  );

endmodule

FILE: rtl/core/pdc_dp.sv
`timescale 1ns / 1ps

module pdc_dp import pdc_pkg::*; #(
  parameter int unsigned FREQ_BITS = FREQ_BITS_DEF
) (
  input  logic        clk,
  input  dp_cmd_t     cmd,
  input  cfg_t        cfg,
  input  logic [1:0]  kind,
  input  logic [31:0] target_frequency,
  output dp_stat_t    stat,
  output logic [1:0]  status,
  output logic [31:0] n_divider,
  output logic [31:0] r_divider
);

  localparam int unsigned W = FREQ_BITS;
  localparam int unsigned TW = (W > 35) ? W : 35;
  localparam int unsigned CW = (W > 32) ? W : 32;
  localparam int unsigned KW = $clog2(W);
  localparam int unsigned SW = $clog2(W);

  logic [TW-1:0] tgt_wide;
  logic [CW-1:0] ref_wide;
  logic [W-1:0]  tgt_in;
  logic [W-1:0]  ref_in;

  logic [W-1:0]  a;
  logic [W-1:0]  b;
  logic [W-1:0]  tgt;
  logic [W-1:0]  refv;
  logic [W-1:0]  g;
  logic [W-1:0]  quo;
  logic [W-1:0]  rem;
  logic [W-1:0]  n_q;
  logic [KW-1:0] k;
  logic [SW-1:0] cnt;
  logic [1:0]    kind_q;

  logic [W:0]    sub_ab;
  logic [W:0]    sub_ba;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;

  logic [CW-1:0] n_ext;
  logic [CW-1:0] r_ext;
  logic [31:0]   n_max;
  logic [31:0]   r_max;
  logic          over;

  // if target scaled by the divider exponent, then cut to the datapath width
  always_comb begin
    if (kind == KIND_IF) begin
      tgt_wide = TW'(target_frequency) << cfg.if_exp;
    end else begin
      tgt_wide = TW'(target_frequency);
    end
    ref_wide = CW'(cfg.osc_hz);
  end

  assign tgt_in = tgt_wide[W-1:0];
  assign ref_in = ref_wide[W-1:0];

  assign sub_ab = {1'b0, a} - {1'b0, b};
  assign sub_ba = {1'b0, b} - {1'b0, a};
  assign rem_sh = {rem, quo[W-1]};
  assign diff   = rem_sh - {1'b0, g};

  assign stat.zero      = (tgt == '0) || (refv == '0);
  assign stat.both_even = !a[0] && !b[0];
  assign stat.gcd_done  = a[0] && b[0] && (a == b);
  assign stat.div_last  = (cnt == SW'(W - 1));

  always_comb begin
    case (kind_q)
      KIND_IF: begin
        n_max = cfg.if_n_max;
        r_max = cfg.if_r_max;
      end
      KIND_RF1: begin
        n_max = cfg.rf1_n_max;
        r_max = cfg.rf1_r_max;
      end
      default: begin
        n_max = cfg.rf2_n_max;
        r_max = cfg.rf2_r_max;
      end
    endcase
    n_ext = CW'(n_q);
    r_ext = CW'(quo);
    over  = (n_ext > CW'(n_max)) || (r_ext > CW'(r_max));
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        a      <= tgt_in;
        b      <= ref_in;
        tgt    <= tgt_in;
        refv   <= ref_in;
        k      <= '0;
        kind_q <= kind;
      end
      OP_HALVE: begin
        a <= a >> 1;
        b <= b >> 1;
        k <= k + 1'b1;
      end
      OP_REDUCE: begin
        if (!a[0]) begin
          a <= a >> 1;
        end else if (!b[0]) begin
          b <= b >> 1;
        end else if (!sub_ab[W]) begin
          a <= {1'b0, sub_ab[W-1:1]};
        end else begin
          b <= {1'b0, sub_ba[W-1:1]};
        end
      end
      OP_INIT_N: begin
        g   <= a << k;
        quo <= tgt;
        rem <= '0;
        cnt <= '0;
      end
      OP_INIT_R: begin
        // last quotient bit of the n division taken on the way
        n_q <= {quo[W-2:0], !diff[W]};
        quo <= refv;
        rem <= '0;
        cnt <= '0;
      end
      OP_DIV: begin
        if (!diff[W]) begin
          rem <= diff[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[W-1:0];
          quo <= {quo[W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
      end
      OP_RESULT: begin
        if (stat.zero) begin
          status    <= ST_ZERO;
          n_divider <= '0;
          r_divider <= '0;
        end else begin
          status    <= over ? ST_RANGE : ST_OK;
          n_divider <= n_ext[31:0];
          r_divider <= r_ext[31:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/core/pdc_ctrl.sv
`timescale 1ns / 1ps

module pdc_ctrl import pdc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CHECK  = 7'b0000010,
    S_HALVE  = 7'b0000100,
    S_REDUCE = 7'b0001000,
    S_DIV_N  = 7'b0010000,
    S_DIV_R  = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_load;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NOP;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = stat.zero ? S_OUT : S_HALVE;
      end
      S_HALVE: begin
        if (stat.both_even) begin
          cmd.op = OP_HALVE;
        end else begin
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (stat.gcd_done) begin
          cmd.op     = OP_INIT_N;
          state_next = S_DIV_N;
        end else begin
          cmd.op = OP_REDUCE;
        end
      end
      S_DIV_N: begin
        if (stat.div_last) begin
          cmd.op     = OP_INIT_R;
          state_next = S_DIV_R;
        end else begin
          cmd.op = OP_DIV;
        end
      end
      S_DIV_R: begin
        cmd.op = OP_DIV;
        if (stat.div_last) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.op     = OP_RESULT;
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= (out_valid && !out_ready) || out_load;
    end
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pdc_pkg::*;

  localparam logic [1:0] KIND_RF2 = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_NONE = 4'd15;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 1500;
  localparam int unsigned ITEMS_PER_PHASE = 125;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] target;
  } freq_request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] n_div;
    logic [31:0] r_div;
  } divider_result_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = '0;
  logic [31:0] target_frequency = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [31:0] n_divider;
  logic [31:0] r_divider;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  freq_request_t pending_requests[$];
  divider_result_t expected_dividers[$];
  cfg_t shadow_cfg;

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  logic [31:0] base_step = 32'd1;

  pll_divider_calc uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .target_frequency(target_frequency),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .n_divider(n_divider),
    .r_divider(r_divider),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] gcd32(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic divider_result_t predict_dividers(input freq_request_t req);
    divider_result_t res;
    logic [31:0] tgt;
    logic [31:0] n_lim;
    logic [31:0] r_lim;
    logic [31:0] g;
    tgt = req.target;
    if (req.kind == KIND_IF) begin
      tgt = tgt << shadow_cfg.if_exp;
      n_lim = shadow_cfg.if_n_max;
      r_lim = shadow_cfg.if_r_max;
    end else if (req.kind == KIND_RF1) begin
      n_lim = shadow_cfg.rf1_n_max;
      r_lim = shadow_cfg.rf1_r_max;
    end else begin
      n_lim = shadow_cfg.rf2_n_max;
      r_lim = shadow_cfg.rf2_r_max;
    end
    if (tgt == 0 || shadow_cfg.osc_hz == 0) begin
      res.status = ST_ZERO;
      res.n_div = '0;
      res.r_div = '0;
    end else begin
      g = gcd32(tgt, shadow_cfg.osc_hz);
      res.n_div = tgt / g;
      res.r_div = shadow_cfg.osc_hz / g;
      res.status = (res.n_div > n_lim || res.r_div > r_lim) ? ST_RANGE : ST_OK;
    end
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_dividers.push_back(predict_dividers({kind, target_frequency}));
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (pending_requests.size() != 0 &&
                   $urandom_range(0, 99) >= sender_idle_pct) begin
        freq_request_t req;
        req = pending_requests.pop_front();
        kind <= req.kind;
        target_frequency <= req.target;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor_proc
    divider_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_dividers.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatches = mismatches + 1;
        end else begin
          want = expected_dividers.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            mismatches = mismatches + 1;
          end
          if (n_divider !== want.n_div) begin
            $error("n_divider: expected %0d, actual %0d", want.n_div, n_divider);
            mismatches = mismatches + 1;
          end
          if (r_divider !== want.r_div) begin
            $error("r_divider: expected %0d, actual %0d", want.r_div, r_divider);
            mismatches = mismatches + 1;
          end
        end
      end
      if (hold_seen != hold_requests) begin
        hold_seen <= hold_requests;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_REF_FREQ: shadow_cfg.osc_hz = data;
      REG_IF_EXP: shadow_cfg.if_exp = data[1:0];
      REG_IF_N_MAX: shadow_cfg.if_n_max = data;
      REG_IF_R_MAX: shadow_cfg.if_r_max = data;
      REG_RF1_N_MAX: shadow_cfg.rf1_n_max = data;
      REG_RF1_R_MAX: shadow_cfg.rf1_r_max = data;
      REG_RF2_N_MAX: shadow_cfg.rf2_n_max = data;
      REG_RF2_R_MAX: shadow_cfg.rf2_r_max = data;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_dividers.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return MAX_RESET;
      default: return $urandom_range(1, 2000);
    endcase
  endfunction

  function automatic logic [31:0] pick_target();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : $urandom;
      2, 3: return $urandom;
      default: return base_step * $urandom_range(1, 2000);
    endcase
  endfunction

  task automatic push_request(input logic [1:0] k, input logic [31:0] t);
    pending_requests.push_back({k, t});
  endtask

  initial begin : stimulus
    logic [31:0] ref_val;
    logic [31:0] r_part;
    logic [31:0] lim;
    shadow_cfg.osc_hz = '0;
    shadow_cfg.if_exp = '0;
    shadow_cfg.if_n_max = MAX_RESET;
    shadow_cfg.if_r_max = MAX_RESET;
    shadow_cfg.rf1_n_max = MAX_RESET;
    shadow_cfg.rf1_r_max = MAX_RESET;
    shadow_cfg.rf2_n_max = MAX_RESET;
    shadow_cfg.rf2_r_max = MAX_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reference still zero after reset
    push_request(KIND_IF, 32'd0);
    push_request(KIND_RF1, 32'd12345);
    push_request(KIND_SPARE, 32'hFFFF_FFFF);
    wait_idle();

    write_register(REG_REF_FREQ, 32'd10_000_000);
    write_register(REG_IF_EXP, 32'd3);
    write_register(REG_IF_N_MAX, MAX_RESET);
    write_register(REG_IF_R_MAX, MAX_RESET);
    write_register(REG_RF1_N_MAX, MAX_RESET);
    write_register(REG_RF1_R_MAX, 32'd1);
    write_register(REG_RF2_N_MAX, 32'd100);
    write_register(REG_RF2_R_MAX, MAX_RESET);
    write_register(REG_NONE, 32'hDEAD_BEEF);
    cfg_valid <= 1'b0;

    push_request(KIND_IF, 32'd0);
    push_request(KIND_IF, 32'h2000_0000);
    push_request(KIND_IF, 32'hFFFF_FFFF);
    push_request(KIND_IF, 32'd1_250_000);
    push_request(KIND_IF, 32'd1);
    push_request(KIND_RF1, 32'd145_000_000);
    push_request(KIND_RF1, 32'd145_000_001);
    push_request(KIND_RF1, 32'hFFFF_FFFF);
    push_request(KIND_RF1, 32'h8000_0000);
    push_request(KIND_RF2, 32'd10_000_001);
    push_request(KIND_RF2, 32'd433_920_000);
    push_request(KIND_RF2, 32'd0);
    push_request(KIND_SPARE, 32'd20_000_000);
    push_request(KIND_SPARE, 32'd1_500_000_000);
    push_request(KIND_SPARE, 32'd0);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      if (p == 2) begin
        ref_val = 32'hFFFF_FFFF;
        base_step = 32'hFFFF_FFFF / 32'd255;
      end else if (p == 5) begin
        ref_val = 32'd1;
        base_step = 32'd1;
      end else begin
        r_part = $urandom_range(1, 1000);
        base_step = $urandom_range(1, 32'hFFFF_FFFF / r_part);
        ref_val = base_step * r_part;
      end
      write_register(REG_REF_FREQ, ref_val);
      write_register(REG_IF_EXP, {30'($urandom_range(0, 32'h3FFF_FFFF)), 2'(p % 4)});
      for (int i = 0; i < 6; i++) begin
        if (p == 6)
          lim = 32'hFFFF_FFFF;
        else if (p == 7)
          lim = 32'd0;
        else
          lim = pick_limit();
        write_register(REG_IF_N_MAX + CFG_INDEX_W'(i), lim);
      end
      write_register(CFG_INDEX_W'($urandom_range(8, 15)), $urandom);
      cfg_valid <= 1'b0;

      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
          hold_requests = hold_requests + 1;
        end
        1: begin
          sender_idle_pct = 55;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 55;
        end
        default: begin
          sender_idle_pct = 26;
          receiver_stall_pct = 26;
        end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        push_request(2'($urandom_range(0, 3)), pick_target());
      wait_idle();
    end

    repeat (200) @(posedge clk);
    if (expected_dividers.size() != 0) begin
      $error("%0d expected results never arrived", expected_dividers.size());
      mismatches = mismatches + 1;
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
